FILE: rtl/double_ended_queue_assert.svh
// assertion macros for the double-ended queue
// used by double_ended_queue.sv, no other dependencies
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, checked only out of reset
`define DQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication, checked only out of reset
`define DQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

FILE: rtl/dq_pkg.sv
// shared types and constants for the double-ended queue
// no dependencies
`default_nettype none

package dq_pkg;

    localparam int unsigned DATA_W = 32;

    // operation codes
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic load;
    } dq_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/dq_datapath.sv
// datapath: ring store, head/tail indices, empty flag and result registers
// depends on dq_pkg
`default_nettype none

module dq_datapath #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire dq_pkg::dq_cmd_t                     cmd,
    input  wire logic [1:0]                          s_operation,
    input  wire logic signed [dq_pkg::DATA_W-1:0]    s_value,
    output logic [1:0]                               m_status,
    output logic signed [dq_pkg::DATA_W-1:0]         m_front_value,
    output logic signed [dq_pkg::DATA_W-1:0]         m_rear_value,
    output logic                                     m_is_empty,
    output logic                                     m_is_full
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [dq_pkg::DATA_W-1:0] ring_mem [DEPTH];

    dq_pkg::op_t               op_reg;
    logic [dq_pkg::DATA_W-1:0] word_reg;
    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          tail_reg, tail_next;
    logic                      empty_reg, empty_next;
    dq_pkg::status_t           status_reg, status_next;
    logic [dq_pkg::DATA_W-1:0] front_rd_reg, rear_rd_reg;

    logic [dq_pkg::DATA_W-1:0] out_front_reg, out_rear_reg;
    dq_pkg::status_t           out_status_reg;
    logic                      out_empty_reg, out_full_reg;

    logic [IDX_W-1:0] tail_inc, tail_dec, head_inc, head_dec;
    logic             full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    // wrapped neighbors of the indices
    always_comb begin
        tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
        tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;
        head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
        full     = !empty_reg && (tail_inc == head_reg);
    end

    // next index state and ring write for one operation
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        status_next = dq_pkg::ST_DONE;
        wr_en       = 1'b0;
        wr_addr     = '0;
        case (op_reg)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
                if (full) begin
                    status_next = dq_pkg::ST_OVERFLOW;
                end else if (empty_reg) begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                end else if (op_reg == dq_pkg::OP_PUSH_FRONT) begin
                    head_next = head_dec;
                    wr_en     = 1'b1;
                    wr_addr   = head_dec;
                end else begin
                    tail_next = tail_inc;
                    wr_en     = 1'b1;
                    wr_addr   = tail_inc;
                end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR: begin
                if (empty_reg) begin
                    status_next = dq_pkg::ST_UNDERFLOW;
                end else if (head_reg == tail_reg) begin
                    empty_next = 1'b1;
                    head_next  = '0;
                    tail_next  = '0;
                end else if (op_reg == dq_pkg::OP_POP_FRONT) begin
                    head_next = head_inc;
                end else begin
                    tail_next = tail_dec;
                end
            end
            default: begin
                status_next = dq_pkg::ST_DONE;
            end
        endcase
    end

    // control state: indices and empty flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end else if (cmd.exec) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    // captured item and operation status
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= dq_pkg::op_t'(s_operation);
            word_reg <= s_value;
        end
        if (cmd.exec) begin
            status_reg <= status_next;
        end
    end

    // ring store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            ring_mem[wr_addr] <= word_reg;
        end
        if (cmd.read) begin
            front_rd_reg <= ring_mem[head_reg];
            rear_rd_reg  <= ring_mem[tail_reg];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_status_reg <= status_reg;
            out_front_reg  <= empty_reg ? '1 : front_rd_reg;
            out_rear_reg   <= empty_reg ? '1 : rear_rd_reg;
            out_empty_reg  <= empty_reg;
            out_full_reg   <= full;
        end
    end

    assign m_status      = out_status_reg;
    assign m_front_value = out_front_reg;
    assign m_rear_value  = out_rear_reg;
    assign m_is_empty    = out_empty_reg;
    assign m_is_full     = out_full_reg;

endmodule

`default_nettype wire

FILE: rtl/dq_ctrl.sv
// controller: sequences capture, update, ring read and result load
// depends on dq_pkg
`default_nettype none

module dq_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output dq_pkg::dq_cmd_t       cmd
);

    typedef enum logic [1:0] {
        IDLE,
        EXEC,
        READ,
        DONE
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   load;

    // result may load once the output register is free or being drained
    assign load = (state_reg == DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        cmd.capture = (state_reg == IDLE) && s_valid;
        cmd.exec    = (state_reg == EXEC);
        cmd.read    = (state_reg == READ);
        cmd.load    = load;
    end

    // state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        state_reg <= EXEC;
                    end
                end
                EXEC: begin
                    state_reg <= READ;
                end
                READ: begin
                    state_reg <= DONE;
                end
                DONE: begin
                    if (load) begin
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue.sv
// Circular double-ended queue over a ring of DEPTH 32-bit words: push or pop at
// either end, one result per operation with status, front and rear words (all
// ones when empty) and empty/full flags. From its transfer until its result is
// loaded into the output register, an item passes through capture, index update
// with ring write, registered read of the head and tail entries, and result
// load, which waits while an unaccepted result is held. The next item is taken
// once the result is loaded, so items do not overlap; this order is set by the
// ring store's registered read port, which must see the write of the same
// operation. The store needs no clearing pass after reset.
// Depends on dq_pkg, dq_ctrl, dq_datapath and double_ended_queue_assert.svh.
`default_nettype none

`include "double_ended_queue_assert.svh"

module double_ended_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_operation,
    input  wire logic signed [dq_pkg::DATA_W-1:0] s_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_status,
    output logic signed [dq_pkg::DATA_W-1:0]      m_front_value,
    output logic signed [dq_pkg::DATA_W-1:0]      m_rear_value,
    output logic                                  m_is_empty,
    output logic                                  m_is_full
);

    dq_pkg::dq_cmd_t cmd;

    // sequencing
    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // storage and result
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_operation   (s_operation),
        .s_value       (s_value),
        .m_status      (m_status),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value),
        .m_is_empty    (m_is_empty),
        .m_is_full     (m_is_full)
    );

    // checks
    `DQ_ASSERT_IMP(a_empty_words, aclk, aresetn, m_valid && m_is_empty, (m_front_value == '1) && (m_rear_value == '1))
    `DQ_ASSERT_IMP(a_overflow_full, aclk, aresetn, m_valid && (m_status == dq_pkg::ST_OVERFLOW), m_is_full)
    `DQ_ASSERT_IMP(a_underflow_empty, aclk, aresetn, m_valid && (m_status == dq_pkg::ST_UNDERFLOW), m_is_empty && !m_is_full)
    `DQ_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `DQ_ASSERT_NEXT(a_load_valid, aclk, aresetn, cmd.load, m_valid)

endmodule

`default_nettype wire
